/* rtl/core/gdft_pkg.sv */
// Shared types and constants of the depth-first graph traversal unit.
`default_nettype none

package gdft_pkg;

  localparam int DefMaxVertices = 64;
  localparam int DefMaxEdges    = 256;
  localparam int VertexWidth    = 6;

  localparam logic ReqEdge     = 1'b0;
  localparam logic ReqTraverse = 1'b1;

  localparam logic KindEdgeAck = 1'b0;
  localparam logic KindVisit   = 1'b1;

  localparam logic EdgeStored  = 1'b0;
  localparam logic EdgeDropped = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StEdgeReadA,
    StEdgeWriteA,
    StEdgeReadB,
    StEdgeWriteB,
    StWalkHead,
    StWalkStep,
    StWalkPop,
    StWalkEntry
  } walk_state_e;

  typedef struct packed {
    logic head_rd;
    logic head_wr;
    logic entry_rd;
    logic entry_wr;
  } adj_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/gdft_adj_store.sv */
// Adjacency list storage: list heads with valid bits and the list entry memory.
`default_nettype none

module gdft_adj_store #(
  parameter int MaxVertices = gdft_pkg::DefMaxVertices,
  parameter int MaxEdges    = gdft_pkg::DefMaxEdges,
  localparam int EntryCount = 2 * MaxEdges,
  localparam int VW         = $clog2(MaxVertices),
  localparam int EI         = (EntryCount > 1) ? $clog2(EntryCount) : 1,
  localparam int EW         = $clog2(EntryCount + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire gdft_pkg::adj_ctrl_t                ctrl_i,
  input  wire logic [VW-1:0]                      head_addr_i,
  input  wire logic [EW-1:0]                      head_wdata_i,
  output logic      [EW-1:0]                      head_rdata_o,
  input  wire logic [EI-1:0]                      entry_addr_i,
  input  wire logic [gdft_pkg::VertexWidth-1:0]   entry_wtarget_i,
  input  wire logic [EW-1:0]                      entry_wlink_i,
  output logic      [gdft_pkg::VertexWidth-1:0]   entry_target_o,
  output logic      [EW-1:0]                      entry_link_o
);
  import gdft_pkg::*;

  localparam logic [EW-1:0] NullLink = EW'(EntryCount);

  logic [EW-1:0]                head_mem [MaxVertices];
  logic [MaxVertices-1:0]       head_valid_q;
  logic [EW-1:0]                head_rdata_q;
  logic                         head_rvalid_q;
  logic [VertexWidth+EW-1:0]    entry_mem [EntryCount];
  logic [VertexWidth+EW-1:0]    entry_rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q  <= '0;
      head_rvalid_q <= 1'b0;
    end else begin
      if (ctrl_i.head_wr) begin
        head_valid_q[head_addr_i] <= 1'b1;
      end
      if (ctrl_i.head_rd) begin
        head_rvalid_q <= head_valid_q[head_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.head_wr) begin
      head_mem[head_addr_i] <= head_wdata_i;
    end
    if (ctrl_i.head_rd) begin
      head_rdata_q <= head_mem[head_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.entry_wr) begin
      entry_mem[entry_addr_i] <= {entry_wtarget_i, entry_wlink_i};
    end
    if (ctrl_i.entry_rd) begin
      entry_rdata_q <= entry_mem[entry_addr_i];
    end
  end

  assign head_rdata_o   = head_rvalid_q ? head_rdata_q : NullLink;
  assign entry_target_o = entry_rdata_q[VertexWidth+EW-1:EW];
  assign entry_link_o   = entry_rdata_q[EW-1:0];

endmodule

`default_nettype wire

/* rtl/core/graph_depth_first_traversal_unit.sv */
// Top level of the depth-first graph traversal unit with its walk sequencer.
// An edge word that fits makes two list head reads and two prepends, then its status word; one out
// of range or without room gets a dropped status word. A traversal word keeps busy high while it
// walks the list head and entry memories through their single read ports; the last word follows.
// A start vertex out of range gives no result and the unit stays ready.
// Reset clears the list heads, the entry count and the visited map; memories need no clearing.
`default_nettype none

module graph_depth_first_traversal_unit #(
  parameter int MAX_VERTICES = gdft_pkg::DefMaxVertices,
  parameter int MAX_EDGES    = gdft_pkg::DefMaxEdges
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              req_type_i,
  input  wire logic [gdft_pkg::VertexWidth-1:0]  vertex_a_i,
  input  wire logic [gdft_pkg::VertexWidth-1:0]  vertex_b_i,
  output logic                                   result_valid_o,
  output logic                                   result_kind_o,
  output logic      [gdft_pkg::VertexWidth-1:0]  visited_vertex_o,
  output logic                                   edge_status_o,
  output logic                                   last_item_o
);
  import gdft_pkg::*;

  localparam int EntryCount = 2 * MAX_EDGES;
  localparam int VW         = $clog2(MAX_VERTICES);
  localparam int EI         = (EntryCount > 1) ? $clog2(EntryCount) : 1;
  localparam int EW         = $clog2(EntryCount + 1);
  localparam int DW         = $clog2(MAX_VERTICES + 1);
  localparam logic [EW-1:0] NullLink = EW'(EntryCount);
  localparam logic [DW-1:0] DepthOne = DW'(1);
  localparam logic [DW-1:0] DepthMax = DW'(MAX_VERTICES);

  walk_state_e state_q, state_d;

  logic                   accept;
  logic [VertexWidth-1:0] vert_a_q, vert_b_q;
  logic [EW-1:0]          used_q, used_d;
  logic [EW-1:0]          cursor_q, cursor_d;
  logic [DW-1:0]          depth_q, depth_d;
  logic [VertexWidth-1:0] pending_q, pending_d;
  logic [MAX_VERTICES-1:0] visited_q;

  logic                   a_in_range, b_in_range, room_ok, nb_in_range, nb_new;
  logic [VW-1:0]          nb_idx;

  adj_ctrl_t              ctrl;
  logic [VW-1:0]          head_addr;
  logic [EW-1:0]          head_wdata, head_rdata;
  logic [EI-1:0]          entry_addr;
  logic [VertexWidth-1:0] entry_wtarget, entry_target;
  logic [EW-1:0]          entry_wlink, entry_link;

  logic                   stack_wr, stack_rd;
  logic [VW-1:0]          stack_addr;
  logic [EW-1:0]          stack_mem [MAX_VERTICES];
  logic [EW-1:0]          stack_rdata_q;

  logic                   visit_clear, visit_set;
  logic [VW-1:0]          visit_idx;

  logic                   emit;
  logic                   emit_kind, emit_status, emit_last;
  logic [VertexWidth-1:0] emit_vertex;

  assign busy       = (state_q != StIdle);
  assign accept     = start && !busy;
  assign a_in_range = (32'(vertex_a_i) < MAX_VERTICES);
  assign b_in_range = (32'(vertex_b_i) < MAX_VERTICES);
  assign room_ok    = ((EW+1)'(used_q) + (EW+1)'(2)) <= (EW+1)'(EntryCount);
  assign nb_in_range = (32'(entry_target) < MAX_VERTICES);
  assign nb_idx     = VW'(entry_target);
  assign nb_new     = nb_in_range && !visited_q[nb_idx];

  gdft_adj_store #(
    .MaxVertices (MAX_VERTICES),
    .MaxEdges    (MAX_EDGES)
  ) u_store (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .head_addr_i     (head_addr),
    .head_wdata_i    (head_wdata),
    .head_rdata_o    (head_rdata),
    .entry_addr_i    (entry_addr),
    .entry_wtarget_i (entry_wtarget),
    .entry_wlink_i   (entry_wlink),
    .entry_target_o  (entry_target),
    .entry_link_o    (entry_link)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_type_i == ReqEdge) begin
            if (a_in_range && b_in_range && room_ok) begin
              state_d = StEdgeReadA;
            end
          end else if (a_in_range) begin
            state_d = StWalkHead;
          end
        end
      end
      StEdgeReadA:  state_d = StEdgeWriteA;
      StEdgeWriteA: state_d = StEdgeReadB;
      StEdgeReadB:  state_d = StEdgeWriteB;
      StEdgeWriteB: state_d = StIdle;
      StWalkHead:   state_d = StWalkStep;
      StWalkStep: begin
        if (cursor_q != NullLink) begin
          state_d = StWalkEntry;
        end else if (depth_q == DepthOne) begin
          state_d = StIdle;
        end else begin
          state_d = StWalkPop;
        end
      end
      StWalkPop: state_d = StWalkStep;
      StWalkEntry: begin
        if (nb_new && depth_q < DepthMax) begin
          state_d = StWalkHead;
        end else begin
          state_d = StWalkStep;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    head_addr     = VW'(vert_a_q);
    head_wdata    = used_q;
    entry_addr    = used_q[EI-1:0];
    entry_wtarget = vert_b_q;
    entry_wlink   = head_rdata;
    stack_wr      = 1'b0;
    stack_rd      = 1'b0;
    stack_addr    = VW'(depth_q - DepthOne);
    visit_clear   = 1'b0;
    visit_set     = 1'b0;
    visit_idx     = VW'(vertex_a_i);
    used_d        = used_q;
    cursor_d      = cursor_q;
    depth_d       = depth_q;
    pending_d     = pending_q;
    emit          = 1'b0;
    emit_kind     = KindVisit;
    emit_vertex   = pending_q;
    emit_status   = EdgeStored;
    emit_last     = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_type_i == ReqEdge) begin
            if (!(a_in_range && b_in_range && room_ok)) begin
              emit        = 1'b1;
              emit_kind   = KindEdgeAck;
              emit_vertex = '0;
              emit_status = EdgeDropped;
              emit_last   = 1'b1;
            end
          end else if (a_in_range) begin
            visit_clear  = 1'b1;
            visit_set    = 1'b1;
            ctrl.head_rd = 1'b1;
            head_addr    = VW'(vertex_a_i);
            pending_d    = vertex_a_i;
            depth_d      = DepthOne;
          end
        end
      end
      StEdgeReadA: begin
        ctrl.head_rd = 1'b1;
      end
      StEdgeWriteA: begin
        ctrl.head_wr  = 1'b1;
        ctrl.entry_wr = 1'b1;
        used_d        = used_q + EW'(1);
      end
      StEdgeReadB: begin
        ctrl.head_rd = 1'b1;
        head_addr    = VW'(vert_b_q);
      end
      StEdgeWriteB: begin
        ctrl.head_wr  = 1'b1;
        ctrl.entry_wr = 1'b1;
        head_addr     = VW'(vert_b_q);
        entry_wtarget = vert_a_q;
        used_d        = used_q + EW'(1);
        emit          = 1'b1;
        emit_kind     = KindEdgeAck;
        emit_vertex   = '0;
        emit_status   = EdgeStored;
        emit_last     = 1'b1;
      end
      StWalkHead: begin
        cursor_d = head_rdata;
      end
      StWalkStep: begin
        if (cursor_q != NullLink) begin
          ctrl.entry_rd = 1'b1;
          entry_addr    = cursor_q[EI-1:0];
        end else if (depth_q == DepthOne) begin
          emit      = 1'b1;
          emit_last = 1'b1;
        end else begin
          depth_d    = depth_q - DepthOne;
          stack_rd   = 1'b1;
          stack_addr = VW'(depth_q - DW'(2));
        end
      end
      StWalkPop: begin
        cursor_d = stack_rdata_q;
      end
      StWalkEntry: begin
        cursor_d = entry_link;
        if (nb_new) begin
          visit_set = 1'b1;
          visit_idx = nb_idx;
          emit      = 1'b1;
          pending_d = entry_target;
          if (depth_q < DepthMax) begin
            stack_wr     = 1'b1;
            depth_d      = depth_q + DepthOne;
            ctrl.head_rd = 1'b1;
            head_addr    = nb_idx;
          end
        end
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      used_q         <= '0;
      depth_q        <= '0;
      visited_q      <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      used_q         <= used_d;
      depth_q        <= depth_d;
      result_valid_o <= emit;
      if (visit_clear) begin
        visited_q <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << visit_idx;
      end else if (visit_set) begin
        visited_q[visit_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vert_a_q <= vertex_a_i;
      vert_b_q <= vertex_b_i;
    end
    cursor_q  <= cursor_d;
    pending_q <= pending_d;
    if (emit) begin
      result_kind_o    <= emit_kind;
      visited_vertex_o <= emit_vertex;
      edge_status_o    <= emit_status;
      last_item_o      <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_wr) begin
      stack_mem[stack_addr] <= entry_link;
    end
    if (stack_rd) begin
      stack_rdata_q <= stack_mem[stack_addr];
    end
  end

`ifndef SYNTHESIS
  a_last_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_item_o |-> !busy)
    else $error("final result word shown while the unit is still busy");

  a_visit_no_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == KindVisit |-> edge_status_o == EdgeStored)
    else $error("visit result word carries an edge status");

  a_entries_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= NullLink)
    else $error("entry count exceeds the entry store");

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && state_q != StEdgeReadA && state_q != StEdgeWriteA && state_q != StEdgeReadB &&
    state_q != StEdgeWriteB |-> depth_q != '0 && depth_q <= DepthMax)
    else $error("walk stack depth out of bounds");
`endif

endmodule

`default_nettype wire
